[sv/tbdc_pkg.sv]
package tbdc_pkg;

  localparam int unsigned DistW  = 10;
  localparam int unsigned CountW = 16;
  localparam int unsigned WinW   = 16;

  localparam logic [DistW-1:0] ThresholdReset = 10'd300;
  localparam logic [WinW-1:0]  WindowReset    = 16'd500;
  localparam logic [CountW-1:0] CountMax      = 16'hFFFF;

  // Operation codes carried in the input tuser.
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_REPORT = 2'd2;

  // Event codes of a result.
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_ENTRY   = 2'd1;
  localparam logic [1:0] EV_EXIT    = 2'd2;
  localparam logic [1:0] EV_TIMEOUT = 2'd3;

  // Wait modes.
  localparam logic [1:0] MODE_IDLE     = 2'd0;
  localparam logic [1:0] MODE_WAIT_FAR = 2'd1;
  localparam logic [1:0] MODE_WAIT_NEAR = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_WINDOW    = 1'b1;

  typedef struct packed {
    logic              near_armed;
    logic              far_armed;
    logic [1:0]        mode;
    logic [WinW-1:0]   elapsed;
    logic [CountW-1:0] entries;
    logic [CountW-1:0] exits;
  } tbdc_state_t;

  typedef struct packed {
    logic [1:0]        wait_mode;
    logic [1:0]        event_code;
    logic [CountW-1:0] exit_count;
    logic [CountW-1:0] entry_count;
  } tbdc_result_t;

endpackage

[sv/tbdc_step.sv]
module tbdc_step
  import tbdc_pkg::*;
(
  input  tbdc_state_t        state,
  input  logic [DistW-1:0]   threshold,
  input  logic [WinW-1:0]    window,
  input  logic [1:0]         op,
  input  logic [DistW-1:0]   near_cm,
  input  logic [DistW-1:0]   far_cm,
  input  logic               link_busy,
  output tbdc_state_t        state_nxt,
  output tbdc_result_t       result
);

  logic [1:0] event_code;

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    sat_inc = (v == CountMax) ? v : v + 1'b1;
  endfunction

  always_comb begin
    state_nxt  = state;
    event_code = EV_NONE;
    case (op)
      OP_SAMPLE: begin
        case (state.mode)
          MODE_IDLE: begin
            if (state.near_armed && (near_cm <= threshold)) begin
              state_nxt.near_armed = 1'b0;
              state_nxt.mode       = MODE_WAIT_FAR;
              state_nxt.elapsed    = '0;
            end else begin
              if (near_cm >= threshold) begin
                state_nxt.near_armed = 1'b1;
              end
              if (state.far_armed && (far_cm <= threshold)) begin
                state_nxt.far_armed = 1'b0;
                state_nxt.mode      = MODE_WAIT_NEAR;
                state_nxt.elapsed   = '0;
              end else if (far_cm >= threshold) begin
                state_nxt.far_armed = 1'b1;
              end
            end
          end
          MODE_WAIT_FAR: begin
            if (far_cm < threshold) begin
              state_nxt.entries = sat_inc(state.entries);
              state_nxt.mode    = MODE_IDLE;
              event_code        = EV_ENTRY;
            end
          end
          MODE_WAIT_NEAR: begin
            if (near_cm < threshold) begin
              state_nxt.exits = sat_inc(state.exits);
              state_nxt.mode  = MODE_IDLE;
              event_code      = EV_EXIT;
            end
          end
          default: begin
          end
        endcase
      end
      OP_TICK: begin
        if ((state.mode == MODE_WAIT_FAR) || (state.mode == MODE_WAIT_NEAR)) begin
          if (state.elapsed >= window) begin
            state_nxt.mode = MODE_IDLE;
            event_code     = EV_TIMEOUT;
          end else begin
            state_nxt.elapsed = state.elapsed + 1'b1;
          end
        end
      end
      OP_REPORT: begin
        if (!link_busy) begin
          state_nxt.entries = '0;
          state_nxt.exits   = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Reported counts are those before a report clears them.
  always_comb begin
    result.entry_count = (op == OP_REPORT) ? state.entries : state_nxt.entries;
    result.exit_count  = (op == OP_REPORT) ? state.exits : state_nxt.exits;
    result.event_code  = event_code;
    result.wait_mode   = state_nxt.mode;
  end

endmodule

[sv/two_beam_direction_counter_core.sv]
// Two-beam direction counter. Each input transaction is a distance sample of
// both sensors, a one millisecond tick or a report request (selected by
// in_tuser), and each one produces exactly one result transaction carrying
// the entry and exit counts, an event code and the wait mode after the step.
// A new transaction is accepted every clock cycle while the output register
// is free or being drained in the same cycle; its result appears in the
// output register in the next cycle, through the single registered pass from
// the state registers to the result register. Threshold and window registers
// are written through the cfg_ port; the user must do so only while the block
// is idle, as the block itself does not enforce it. Reset loads 300 cm and 500 ms.
module two_beam_direction_counter_core
  import tbdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // near_distance_cm[9:0], far_distance_cm[19:10],
                                  // link_busy[20], zero fill[23:21]
  input  logic [1:0]  in_tuser,   // op[1:0]
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // entry_count[15:0], exit_count[31:16],
                                  // event_code[33:32], wait_mode[35:34], zero fill[39:36]
);

  logic [DistW-1:0] threshold_r;
  logic [WinW-1:0]  window_r;
  tbdc_state_t      state_r;
  tbdc_state_t      state_nxt;
  tbdc_result_t     result_nxt;
  tbdc_result_t     result_r;
  logic             out_valid_r;
  logic             in_acc;

  // The result register is free when empty or drained in this cycle.
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= ThresholdReset;
      window_r    <= WindowReset;
    end else if (cfg_we) begin
      if (cfg_index == CFG_THRESHOLD) begin
        threshold_r <= cfg_wdata[DistW-1:0];
      end else begin
        window_r <= cfg_wdata[WinW-1:0];
      end
    end
  end

  tbdc_step u_step (
    .state     (state_r),
    .threshold (threshold_r),
    .window    (window_r),
    .op        (in_tuser),
    .near_cm   (in_tdata[9:0]),
    .far_cm    (in_tdata[19:10]),
    .link_busy (in_tdata[20]),
    .state_nxt (state_nxt),
    .result    (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.near_armed <= 1'b1;
      state_r.far_armed  <= 1'b1;
      state_r.mode       <= MODE_IDLE;
      state_r.elapsed    <= '0;
      state_r.entries    <= '0;
      state_r.exits      <= '0;
      out_valid_r        <= 1'b0;
    end else begin
      if (in_acc) begin
        state_r <= state_nxt;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload needs no reset; it is qualified by out_valid_r.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      result_r <= result_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, result_r.wait_mode, result_r.event_code,
                       result_r.exit_count, result_r.entry_count};

`ifndef SYNTHESIS
  // Waiting for the far beam means the near beam fired and has not re-armed.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.mode == MODE_WAIT_FAR) |-> !state_r.near_armed)
    else $error("near beam armed while waiting for far beam");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.mode == MODE_WAIT_NEAR) |-> !state_r.far_armed)
    else $error("far beam armed while waiting for near beam");

  // Any counted or timed-out event closes the window.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (result_r.event_code != EV_NONE)) |->
      (result_r.wait_mode == MODE_IDLE))
    else $error("event reported with window still open");

  // A report on a free link clears both counts.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser == OP_REPORT) && !in_tdata[20]) |=>
      ((state_r.entries == '0) && (state_r.exits == '0)))
    else $error("counts not cleared by report");
`endif

endmodule

[dv/two_beam_direction_counter_core_test.sv]
module two_beam_direction_counter_core_test;
  import tbdc_pkg::*;

  // Predicts every result of the counter from the transactions that were
  // accepted, and keeps the predicted results in arrival order.
  class direction_tally;
    logic [DistW-1:0]  threshold;
    logic [WinW-1:0]   window;
    logic              near_armed;
    logic              far_armed;
    logic [1:0]        mode;
    logic [WinW-1:0]   elapsed;
    logic [CountW-1:0] entries;
    logic [CountW-1:0] exits;
    tbdc_result_t      pending_tallies[$];
    int                errors;

    function new();
      threshold  = ThresholdReset;
      window     = WindowReset;
      near_armed = 1'b1;
      far_armed  = 1'b1;
      mode       = MODE_IDLE;
      elapsed    = '0;
      entries    = '0;
      exits      = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic idx, logic [15:0] value);
      if (idx == CFG_THRESHOLD) begin
        threshold = value[DistW-1:0];
      end else begin
        window = value;
      end
    endfunction

    function void accept_item(logic [1:0] op, logic [9:0] near_cm, logic [9:0] far_cm,
                              logic busy);
      tbdc_result_t want;
      want.event_code = EV_NONE;
      case (op)
        OP_SAMPLE: begin
          if (mode == MODE_IDLE) begin
            // The near beam wins when both are interrupted; the far reading
            // is then not looked at.
            if (near_armed && near_cm <= threshold) begin
              near_armed = 1'b0;
              mode       = MODE_WAIT_FAR;
              elapsed    = '0;
            end else begin
              if (near_cm >= threshold) near_armed = 1'b1;
              if (far_armed && far_cm <= threshold) begin
                far_armed = 1'b0;
                mode      = MODE_WAIT_NEAR;
                elapsed   = '0;
              end else if (far_cm >= threshold) begin
                far_armed = 1'b1;
              end
            end
          end else if (mode == MODE_WAIT_FAR) begin
            if (far_cm < threshold) begin
              entries         = (entries == CountMax) ? entries : entries + 1'b1;
              want.event_code = EV_ENTRY;
              mode            = MODE_IDLE;
            end
          end else if (mode == MODE_WAIT_NEAR) begin
            if (near_cm < threshold) begin
              exits           = (exits == CountMax) ? exits : exits + 1'b1;
              want.event_code = EV_EXIT;
              mode            = MODE_IDLE;
            end
          end
        end
        OP_TICK: begin
          if (mode == MODE_WAIT_FAR || mode == MODE_WAIT_NEAR) begin
            if (elapsed >= window) begin
              want.event_code = EV_TIMEOUT;
              mode            = MODE_IDLE;
            end else begin
              elapsed = elapsed + 1'b1;
            end
          end
        end
        default: ;
      endcase
      want.entry_count = entries;
      want.exit_count  = exits;
      want.wait_mode   = mode;
      if (op == OP_REPORT && !busy) begin
        entries = '0;
        exits   = '0;
      end
      pending_tallies.push_back(want);
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_result(logic [39:0] data);
      tbdc_result_t got;
      tbdc_result_t want;
      got = tbdc_result_t'(data[35:0]);
      if (pending_tallies.size() == 0) begin
        note_error($sformatf("result %h arrived with nothing outstanding", data));
      end else begin
        want = pending_tallies.pop_front();
        if (got.entry_count != want.entry_count || got.exit_count != want.exit_count ||
            got.event_code != want.event_code || got.wait_mode != want.wait_mode) begin
          note_error($sformatf(
              "entries %0d/%0d exits %0d/%0d event %0d/%0d mode %0d/%0d (expected/actual)",
              want.entry_count, got.entry_count, want.exit_count, got.exit_count,
              want.event_code, got.event_code, want.wait_mode, got.wait_mode));
        end
      end
    endfunction

    function int waiting();
      return pending_tallies.size();
    endfunction
  endclass

  // Kinds of distance picked relative to the current threshold.
  localparam int DIST_LOW  = 0;
  localparam int DIST_HIGH = 1;
  localparam int DIST_ANY  = 2;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic        cfg_index  = CFG_THRESHOLD;
  logic [15:0] cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;  // near_distance_cm[9:0], far_distance_cm[19:10],
                                 // link_busy[20], zero fill[23:21]
  logic [1:0]  in_tuser   = OP_SAMPLE;  // op[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;        // entry_count[15:0], exit_count[31:16],
                                 // event_code[33:32], wait_mode[35:34], zero fill[39:36]

  direction_tally tally = new();

  // Cycles the result side still holds out_tready low.
  int rx_wait = 0;

  two_beam_direction_counter_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Result side. Every accepted result transaction is checked against the
  // oldest prediction, and a fresh random stall is drawn for the next one.
  // The countdown also runs while nothing is offered, so the stalls fall on
  // every phase of the block's work.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        tally.check_result(out_tdata);
        rx_wait = $urandom_range(0, 10);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_tready <= (rx_wait == 0);
    end
  end

  // Picks a distance below, above or anywhere around the current threshold.
  // A quarter of the picks land exactly on the threshold, where "at or
  // below" and "strictly below" part ways.
  function automatic logic [9:0] pick_distance(int kind);
    logic [9:0] thr;
    thr = tally.threshold;
    if ($urandom_range(0, 3) == 0) return thr;
    case (kind)
      DIST_LOW:  return 10'($urandom_range(0, thr));
      DIST_HIGH: return 10'($urandom_range(thr, 1023));
      default:   return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  // Offers one input transaction after a random gap and waits until it is
  // taken. in_tvalid stays high between transactions sent without a gap.
  task automatic send_item(input logic [1:0] op, input logic [9:0] near_cm,
                           input logic [9:0] far_cm, input logic busy);
    int gap;
    gap = $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tuser  <= op;
    in_tdata  <= {3'b000, busy, far_cm, near_cm};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    tally.accept_item(op, near_cm, far_cm, busy);
  endtask

  task automatic sample(input logic [9:0] near_cm, input logic [9:0] far_cm);
    send_item(OP_SAMPLE, near_cm, far_cm, 1'($urandom_range(0, 1)));
  endtask

  // Distances and the busy flag mean nothing for a tick; they are random so
  // that every data bit toggles.
  task automatic tick();
    send_item(OP_TICK, 10'($urandom), 10'($urandom), 1'($urandom_range(0, 1)));
  endtask

  task automatic report(input logic busy);
    send_item(OP_REPORT, 10'($urandom), 10'($urandom), busy);
  endtask

  // Stops offering input and waits until every predicted result came back.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tally.waiting() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Writes both registers on consecutive cycles; only called when settled.
  task automatic set_config(input logic [9:0] thr, input logic [15:0] win);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_THRESHOLD;
    cfg_wdata <= {6'd0, thr};
    @(posedge clk);
    cfg_index <= CFG_WINDOW;
    cfg_wdata <= win;
    @(posedge clk);
    cfg_we <= 1'b0;
    tally.write_reg(CFG_THRESHOLD, {6'd0, thr});
    tally.write_reg(CFG_WINDOW, win);
    @(posedge clk);
  endtask

  // Random traffic. Most of it is well-formed passages: one beam opens a
  // window, a few ticks pass, and the other beam is read. Re-arming samples,
  // reports, stray ticks and fully random samples fill the rest.
  task automatic run_traffic(input int n_items);
    int sent;
    int k;
    int span;
    sent = 0;
    while (sent < n_items) begin
      // Tick runs long enough to cross the window only when it is short.
      span = (tally.window < 16) ? int'(tally.window) + 2 : 4;
      k    = $urandom_range(0, span);
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // Walking in: near beam first.
          sample(pick_distance(DIST_LOW), pick_distance(DIST_ANY));
          repeat (k) tick();
          sample(pick_distance(DIST_ANY), pick_distance(DIST_LOW));
          sent += k + 2;
        end
        3, 4, 5: begin
          // Walking out: far beam first.
          sample(pick_distance(DIST_HIGH), pick_distance(DIST_LOW));
          repeat (k) tick();
          sample(pick_distance(DIST_LOW), pick_distance(DIST_ANY));
          sent += k + 2;
        end
        6: begin
          sample(pick_distance(DIST_HIGH), pick_distance(DIST_HIGH));
          sent += 1;
        end
        7: begin
          report(1'($urandom_range(0, 1)));
          sent += 1;
        end
        8: begin
          k = $urandom_range(1, 3);
          repeat (k) tick();
          sent += k;
        end
        default: begin
          sample(pick_distance(DIST_ANY), pick_distance(DIST_ANY));
          sent += 1;
        end
      endcase
    end
  endtask

  // Settings for the random phases: both extremes of each register first,
  // then a few random thresholds with short windows so that timeouts occur.
  logic [9:0]  phase_thr[8] = '{10'd0, 10'd1023, 10'd300, 10'd1, 10'd512, 10'd0, 10'd0, 10'd0};
  logic [15:0] phase_win[8] = '{16'd0, 16'd65535, 16'd1, 16'd3, 16'd500, 16'd0, 16'd0, 16'd0};

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset settings (300 cm, 500 ms).
    report(1'b0);                    // counts start at zero
    sample(10'd0, 10'd1023);         // near opens the window, far not looked at
    tick();
    tick();
    sample(10'd1023, 10'd300);       // far exactly at threshold is not below it
    sample(10'd1023, 10'd299);       // entry
    sample(10'd300, 10'd1023);       // near re-arms at threshold, nothing opens
    sample(10'd1023, 10'd300);       // far opens at threshold
    sample(10'd300, 10'd0);          // near at threshold does not close it
    sample(10'd0, 10'd1023);         // exit
    report(1'b1);                    // busy link: counts are kept
    report(1'b0);                    // counts returned and cleared
    report(1'b0);
    sample(10'd100, 10'd100);        // both interrupted: the near beam wins
    sample(10'd1023, 10'd1023);      // waiting, far not interrupted
    settle();

    // Short window: the third tick finds the window used up.
    set_config(10'd300, 16'd2);
    tick();
    tick();
    tick();
    tick();                          // a tick while idle changes nothing
    sample(10'd0, 10'd1023);         // near still disarmed, so no window opens
    sample(10'd1023, 10'd1023);      // near beam re-arms; far is armed already
    settle();

    // Random phases, one per setting.
    for (int p = 0; p < 8; p++) begin
      if (p >= 5) begin
        phase_thr[p] = 10'($urandom_range(0, 1023));
        phase_win[p] = 16'($urandom_range(0, 12));
      end
      set_config(phase_thr[p], phase_win[p]);
      run_traffic(200);
      settle();
    end

    report(1'b1);
    report(1'b0);
    report(1'b0);

    // Drain, then allow a few cycles for any result nobody asked for.
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tally.waiting() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    if (tally.errors == 0 && tally.waiting() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: ends the run with FAIL if it hangs.
  initial begin
    #30000000;
    $display("FAIL");
    $finish;
  end

endmodule
